[hw/rtl/tpf_pkg.sv]
// tpf_pkg: shared widths, register indexes and the peak emission struct for
// the threshold peak finder. No dependencies.
`default_nettype none

package tpf_pkg;

    localparam int SAMPLE_W            = 16;
    localparam int IDX_OUT_W           = 10;
    localparam int FRAC_W              = 15;
    localparam int DIST_W              = 10;
    localparam int PEAKS_W             = 7;
    localparam int SLOT_LIMIT          = 64;
    localparam int PROD_W              = (SAMPLE_W - 1) + FRAC_W;
    localparam int FRAME_DEPTH_DEFAULT = 1024;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD_FRACTION = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DISTANCE       = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_PEAKS          = 2'd2;

    localparam logic [FRAC_W-1:0]  THRESHOLD_FRACTION_RST = 15'd16384;
    localparam logic [DIST_W-1:0]  MIN_DISTANCE_RST       = 10'd1;
    localparam logic [PEAKS_W-1:0] MAX_PEAKS_RST          = 7'd8;

    // one result slot handed from the scanner to the output register
    typedef struct packed {
        logic                 valid;
        logic [IDX_OUT_W-1:0] index;
        logic                 filled;
        logic                 last;
    } tpf_emit_t;

endpackage

`default_nettype wire

[hw/rtl/tpf_sample_mem.sv]
// tpf_sample_mem: sample store, one write port and one read port with the
// read data registered. Uses tpf_pkg.
`default_nettype none

module tpf_sample_mem #(
    parameter int FRAME_DEPTH = tpf_pkg::FRAME_DEPTH_DEFAULT,
    parameter int AW          = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1
) (
    input  wire logic                              clk,
    input  wire logic                              wr_en,
    input  wire logic [AW-1:0]                     wr_addr,
    input  wire logic signed [tpf_pkg::SAMPLE_W-1:0] wr_data,
    input  wire logic [AW-1:0]                     rd_addr,
    output logic signed [tpf_pkg::SAMPLE_W-1:0]    rd_data
);
    import tpf_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [FRAME_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hw/rtl/tpf_peak_scan.sv]
// tpf_peak_scan: post-frame search. Computes the threshold, emits the global
// peak, walks the sample store left then right, then pads. Uses tpf_pkg.
`default_nettype none

module tpf_peak_scan #(
    parameter int FRAME_DEPTH = tpf_pkg::FRAME_DEPTH_DEFAULT,
    parameter int AW          = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1,
    parameter int CNTW        = $clog2(FRAME_DEPTH + 1)
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [AW-1:0]                       top_pos,
    input  wire logic [CNTW-1:0]                     frame_count,
    input  wire logic signed [tpf_pkg::SAMPLE_W-1:0] frame_max,
    input  wire logic [tpf_pkg::FRAC_W-1:0]          thr_frac,
    input  wire logic [tpf_pkg::DIST_W-1:0]          min_dist,
    input  wire logic [tpf_pkg::PEAKS_W-1:0]         max_peaks,
    input  wire logic                                out_free,
    output logic [AW-1:0]                            rd_addr,
    input  wire logic signed [tpf_pkg::SAMPLE_W-1:0] rd_data,
    output tpf_pkg::tpf_emit_t                       emit,
    output logic                                     done
);
    import tpf_pkg::*;

    localparam int PW = ((AW > IDX_OUT_W) ? AW : IDX_OUT_W) + 2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_THR   = 6'b000010,
        S_PEAK  = 6'b000100,
        S_LEFT  = 6'b001000,
        S_RIGHT = 6'b010000,
        S_PAD   = 6'b100000
    } scan_state_t;

    scan_state_t                state_reg, state_next;
    logic [PEAKS_W-1:0]         cnt_reg, cnt_next;
    logic                       rvalid_reg, rvalid_next;
    logic [1:0]                 fill_reg, fill_next;
    logic [FRAC_W-1:0]          thr_reg, thr_next;
    logic signed [PW-1:0]       cand_reg, cand_next;
    logic signed [PW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic signed [SAMPLE_W-1:0] w1_reg, w1_next;
    logic signed [SAMPLE_W-1:0] w2_reg, w2_next;

    logic [PEAKS_W-1:0]         slots;
    logic [DIST_W-1:0]          dist_u;
    logic signed [PW-1:0]       dist_s, top_s, n_s, step_s, jump_s;
    logic signed [SAMPLE_W-1:0] thr_s;
    logic [PROD_W-1:0]          prod;
    logic                       last_emit, in_range, hit, left;

    always_comb
    begin
        if (max_peaks == '0)
            slots = PEAKS_W'(1);
        else if (max_peaks > PEAKS_W'(SLOT_LIMIT))
            slots = PEAKS_W'(SLOT_LIMIT);
        else
            slots = max_peaks;
    end

    assign dist_u    = (min_dist == '0) ? DIST_W'(1) : min_dist;
    assign dist_s    = signed'({{(PW-DIST_W){1'b0}}, dist_u});
    assign top_s     = signed'({{(PW-AW){1'b0}}, top_pos});
    assign n_s       = signed'({{(PW-CNTW){1'b0}}, frame_count});
    assign left      = (state_reg == S_LEFT);
    assign step_s    = left ? {PW{1'b1}} : PW'(1);
    assign jump_s    = left ? -dist_s : dist_s;
    assign thr_s     = signed'({1'b0, thr_reg});
    assign prod      = PROD_W'(frame_max[SAMPLE_W-2:0]) * PROD_W'(thr_frac);
    assign last_emit = ((cnt_reg + PEAKS_W'(1)) == slots);
    assign in_range  = left ? (cand_reg >= PW'(1)) : ((cand_reg + PW'(2)) <= n_s);
    // candidate is w2; w1 and the arriving word are its neighbors
    assign hit       = (w2_reg > thr_s) && (w2_reg > w1_reg) && (w2_reg > rd_data);
    assign rd_addr   = rd_ptr_reg[AW-1:0];

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rvalid_next = 1'b0;
        fill_next   = fill_reg;
        thr_next    = thr_reg;
        cand_next   = cand_reg;
        rd_ptr_next = rd_ptr_reg;
        w1_next     = w1_reg;
        w2_next     = w2_reg;
        emit        = '0;
        done        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_THR;
            end
            S_THR:
            begin
                thr_next   = prod[PROD_W-1:FRAC_W];
                cnt_next   = '0;
                state_next = S_PEAK;
            end
            S_PEAK:
            begin
                if (out_free)
                begin
                    emit.valid  = 1'b1;
                    emit.index  = top_s[IDX_OUT_W-1:0];
                    emit.filled = 1'b1;
                    emit.last   = last_emit;
                    cnt_next    = cnt_reg + PEAKS_W'(1);
                    if (last_emit)
                    begin
                        done       = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cand_next   = top_s - dist_s;
                        rd_ptr_next = top_s - dist_s + PW'(1);
                        fill_next   = '0;
                        state_next  = S_LEFT;
                    end
                end
            end
            S_LEFT, S_RIGHT:
            begin
                if (!in_range)
                begin
                    fill_next = '0;
                    if (left)
                    begin
                        cand_next   = top_s + dist_s;
                        rd_ptr_next = top_s + dist_s - PW'(1);
                        state_next  = S_RIGHT;
                    end
                    else
                    begin
                        state_next = S_PAD;
                    end
                end
                else
                begin
                    rvalid_next = 1'b1;
                    rd_ptr_next = rd_ptr_reg + step_s;
                    if (rvalid_reg)
                    begin
                        if (fill_reg == 2'd2)
                        begin
                            if (hit)
                            begin
                                rvalid_next = 1'b0;
                                fill_next   = '0;
                                if (out_free)
                                begin
                                    emit.valid  = 1'b1;
                                    emit.index  = cand_reg[IDX_OUT_W-1:0];
                                    emit.filled = 1'b1;
                                    emit.last   = last_emit;
                                    cnt_next    = cnt_reg + PEAKS_W'(1);
                                    if (last_emit)
                                    begin
                                        done       = 1'b1;
                                        state_next = S_IDLE;
                                    end
                                    else
                                    begin
                                        cand_next   = cand_reg + jump_s;
                                        rd_ptr_next = cand_reg + jump_s - step_s;
                                    end
                                end
                                else
                                begin
                                    // output busy: refetch the window, same candidate
                                    rd_ptr_next = cand_reg - step_s;
                                end
                            end
                            else
                            begin
                                w1_next   = w2_reg;
                                w2_next   = rd_data;
                                cand_next = cand_reg + step_s;
                            end
                        end
                        else
                        begin
                            w1_next   = w2_reg;
                            w2_next   = rd_data;
                            fill_next = fill_reg + 2'd1;
                        end
                    end
                end
            end
            S_PAD:
            begin
                if (out_free)
                begin
                    emit.valid  = 1'b1;
                    emit.index  = '0;
                    emit.filled = 1'b0;
                    emit.last   = last_emit;
                    cnt_next    = cnt_reg + PEAKS_W'(1);
                    if (last_emit)
                    begin
                        done       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            rvalid_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rvalid_reg <= rvalid_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        thr_reg    <= thr_next;
        cand_reg   <= cand_next;
        rd_ptr_reg <= rd_ptr_next;
        w1_reg     <= w1_next;
        w2_reg     <= w2_next;
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> out_free)
        else $error("slot emitted while output register full");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.valid && emit.last) |-> done)
        else $error("last slot without frame completion");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == S_IDLE))
        else $error("new frame started while search in progress");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rvalid_reg && (fill_reg == 2'd2)) |=> (fill_reg != 2'd3))
        else $error("window fill count out of range");

endmodule

`default_nettype wire

[hw/rtl/threshold_peak_finder.sv]
// threshold_peak_finder: top level. Config registers, frame loader, output
// register; instantiates tpf_sample_mem and tpf_peak_scan. Uses tpf_pkg.
//
// Frame-based peak finder. Samples stream in on s_* one per cycle and are
// written to a single-port-write / single-port-read sample store while the
// first strictly largest positive sample is tracked. The sample with s_tlast
// closes the frame; samples beyond FRAME_DEPTH are dropped (still accepted).
// After frame end, s_tready stays low while the search runs: first the
// threshold multiply (max * threshold_fraction >> 15), then the global
// peak is emitted, then the store is walked left from peak - min_distance
// and right from peak + min_distance. The store's one read port sets the
// pace, and the three-sample window is refilled after each hit (or after a
// stall on m_tready). Then empty slots pad out to max_peaks, one per cycle
// while the output register is free. Every frame yields exactly max_peaks
// transactions on m_* (0 taken as 1, above 64 clamped to 64), the last with
// m_tlast. Loads and scans never overlap, so the store needs no forwarding.
// No clearing pass after reset.
`default_nettype none

module threshold_peak_finder #(
    parameter int FRAME_DEPTH = tpf_pkg::FRAME_DEPTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [tpf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [tpf_pkg::CFG_DATA_W-1:0]    cfg_data,
    // sample stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [15:0]                       s_tdata,  // [15:0] sample
    input  wire logic                              s_tlast,  // frame_end
    // peak slot stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [15:0]                            m_tdata,  // [9:0] peak_index, [15:10] zero
    output logic                                   m_tuser,  // [0] slot_filled
    output logic                                   m_tlast   // last_slot
);
    import tpf_pkg::*;

    localparam int AW   = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int CNTW = $clog2(FRAME_DEPTH + 1);

    // configuration registers
    logic [FRAC_W-1:0]  thr_frac_reg;
    logic [DIST_W-1:0]  min_dist_reg;
    logic [PEAKS_W-1:0] max_peaks_reg;

    // frame loader state
    logic                       busy_reg, busy_next;
    logic [CNTW-1:0]            count_reg, count_next;
    logic signed [SAMPLE_W-1:0] run_max_reg, run_max_next;
    logic [AW-1:0]              max_pos_reg, max_pos_next;

    // output register
    logic                 m_tvalid_reg;
    logic [IDX_OUT_W-1:0] m_index_reg;
    logic                 m_filled_reg;
    logic                 m_last_reg;

    logic                       accept, store_ok, start, out_free, scan_done;
    logic signed [SAMPLE_W-1:0] sample_s, rd_data;
    logic [AW-1:0]              rd_addr;
    tpf_emit_t                  emit;

    assign sample_s = signed'(s_tdata);
    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign store_ok = (count_reg < CNTW'(FRAME_DEPTH));
    assign start    = accept && s_tlast;
    assign out_free = !m_tvalid_reg || m_tready;

    // config writes must happen only while idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_frac_reg  <= THRESHOLD_FRACTION_RST;
            min_dist_reg  <= MIN_DISTANCE_RST;
            max_peaks_reg <= MAX_PEAKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_THRESHOLD_FRACTION: thr_frac_reg  <= cfg_data[FRAC_W-1:0];
                CFG_MIN_DISTANCE:       min_dist_reg  <= cfg_data[DIST_W-1:0];
                CFG_MAX_PEAKS:          max_peaks_reg <= cfg_data[PEAKS_W-1:0];
                default:                ;
            endcase
        end
    end

    // loader: count, running max and its position; cleared when search ends
    always_comb
    begin
        busy_next    = busy_reg;
        count_next   = count_reg;
        run_max_next = run_max_reg;
        max_pos_next = max_pos_reg;
        priority if (scan_done)
        begin
            busy_next    = 1'b0;
            count_next   = '0;
            run_max_next = '0;
            max_pos_next = '0;
        end
        else if (accept)
        begin
            if (store_ok)
            begin
                count_next = count_reg + CNTW'(1);
                if (sample_s > run_max_reg)
                begin
                    run_max_next = sample_s;
                    max_pos_next = count_reg[AW-1:0];
                end
            end
            if (s_tlast)
                busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            count_reg   <= '0;
            run_max_reg <= '0;
            max_pos_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            count_reg   <= count_next;
            run_max_reg <= run_max_next;
            max_pos_reg <= max_pos_next;
        end
    end

    tpf_sample_mem #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .AW          (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (accept && store_ok),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (sample_s),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tpf_peak_scan #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .AW          (AW),
        .CNTW        (CNTW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .top_pos     (max_pos_reg),
        .frame_count (count_reg),
        .frame_max   (run_max_reg),
        .thr_frac    (thr_frac_reg),
        .min_dist    (min_dist_reg),
        .max_peaks   (max_peaks_reg),
        .out_free    (out_free),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .emit        (emit),
        .done        (scan_done)
    );

    // output register: scanner only emits when out_free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            m_index_reg  <= emit.index;
            m_filled_reg <= emit.filled;
            m_last_reg   <= emit.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(16-IDX_OUT_W){1'b0}}, m_index_reg};
    assign m_tuser  = m_filled_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// tb_top: self-checking bench for threshold_peak_finder. Streams frames of Q15
// samples, predicts every peak slot in-bench and compares each m_* transaction.
// Depends on tpf_pkg and threshold_peak_finder with tpf_sample_mem and tpf_peak_scan.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tpf_pkg::*;

    localparam int DEPTH        = FRAME_DEPTH_DEFAULT;
    // longest correct quiet stretch is one full scan of the store plus window
    // refills, with a receiver stall on top; keep a wide margin
    localparam int QUIET_LIMIT  = 8000;
    localparam int SETTLE       = 16;   // cycles let pass once the slot queue is empty
    localparam int RANDOM_ITEMS = 100;
    localparam int N_SETTINGS   = 6;
    localparam int SHOW_LIMIT   = 40;   // mismatch lines printed before going quiet

    // index 3 decodes to no register; writes there must change nothing
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;
    // marks a directed row whose expected peak is left to the predictor
    localparam logic [10:0] NO_PEAK = 11'h7FF;

    typedef enum int {
        SHAPE_NOISE,
        SHAPE_BUMPS,
        SHAPE_NEGATIVE,
        SHAPE_PLATEAU,
        SHAPE_ZIGZAG
    } frame_shape_e;

    // one directed row: a sample, its frame_end flag, and (on frame ends that
    // are obvious) the global peak index typed in by hand
    typedef struct packed {
        logic [15:0] value;
        logic        last;
        logic [10:0] peak;
    } vector_t;

    typedef struct packed {
        logic [FRAC_W-1:0]  fraction;
        logic [DIST_W-1:0]  spacing;
        logic [PEAKS_W-1:0] slots;
    } setting_t;

    typedef struct {
        logic [IDX_OUT_W-1:0] index;
        logic                 filled;
        logic                 last;
    } peak_slot_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;     // [15:0] sample
    logic                  s_tlast;     // frame_end
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;     // [9:0] peak_index, [15:10] zero
    logic                  m_tuser;     // [0] slot_filled
    logic                  m_tlast;     // last_slot
    // travels with each sample transaction so the monitor sees the typed
    // expectation of the very item being accepted
    logic [10:0]           typed_peak;

    // predictor state: shadow registers and the frame being loaded
    logic [FRAC_W-1:0]  thr_fraction;
    logic [DIST_W-1:0]  peak_spacing;
    logic [PEAKS_W-1:0] peak_limit;
    int                 sample_copy[DEPTH];
    int                 frame_len;
    int                 frame_max;
    int                 frame_top;

    peak_slot_t   pending_slots[$];
    logic [15:0]  frame_q[$];

    int mismatches;
    int quiet_cycles;
    int slots_checked;
    int frames_closed;
    int samples_sent;

    threshold_peak_finder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // strict local maximum above the threshold
    function automatic bit is_local_peak(input int i, input int floor_level);
        return sample_copy[i] > floor_level && sample_copy[i] > sample_copy[i - 1]
            && sample_copy[i] > sample_copy[i + 1];
    endfunction

    // Frame end: global peak first, then the left scan, then the right scan,
    // each hit pushing the next candidate min_distance away. Every frame
    // yields exactly max_peaks slots (0 taken as 1, at most 64), padded with empty ones.
    function automatic void close_frame(input logic [10:0] typed);
        int hits[$];
        int slots;
        int hop;
        int thr;
        int i;
        peak_slot_t slot;
        slots = (peak_limit == 0) ? 1 : (peak_limit > SLOT_LIMIT ? SLOT_LIMIT : int'(peak_limit));
        hop   = (peak_spacing == 0) ? 1 : int'(peak_spacing);
        // frame_max is never negative, so the Q15 product fits an int
        thr   = (frame_max * int'(thr_fraction)) >>> 15;
        hits.push_back(frame_top);
        for (i = frame_top - hop; i > 0 && hits.size() < slots; i--)
        begin
            if (is_local_peak(i, thr))
            begin
                hits.push_back(i);
                i = i - hop + 1;
            end
        end
        for (i = frame_top + hop; i < frame_len - 1 && hits.size() < slots; i++)
        begin
            if (is_local_peak(i, thr))
            begin
                hits.push_back(i);
                i = i + hop - 1;
            end
        end
        // hand-typed rows carry only the global peak by construction
        if (typed != NO_PEAK)
        begin
            hits.delete();
            hits.push_back(int'(typed));
        end
        for (i = 0; i < slots; i++)
        begin
            slot.filled = (i < hits.size());
            slot.index  = slot.filled ? IDX_OUT_W'(hits[i]) : '0;
            slot.last   = (i == slots - 1);
            pending_slots.push_back(slot);
        end
        frame_len = 0;
        frame_max = 0;
        frame_top = 0;
        frames_closed++;
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
            $display("%0t ns: %s mismatch, got %0d want %0d", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Monitor: register shadow, sample capture, slot checking, quiet count.
    // Everything is sampled in one block at the rising edge, before any of
    // that edge's nonblocking updates land.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        peak_slot_t want;
        if (!rst_n)
        begin
            thr_fraction = THRESHOLD_FRACTION_RST;
            peak_spacing = MIN_DISTANCE_RST;
            peak_limit   = MAX_PEAKS_RST;
            frame_len    = 0;
            frame_max    = 0;
            frame_top    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_THRESHOLD_FRACTION: thr_fraction = cfg_data[FRAC_W-1:0];
                    CFG_MIN_DISTANCE:       peak_spacing = cfg_data[DIST_W-1:0];
                    CFG_MAX_PEAKS:          peak_limit   = cfg_data[PEAKS_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                samples_sent++;
                // past the store depth samples are still taken but dropped; their
                // frame_end still closes the frame, which then holds full depth
                if (frame_len < DEPTH)
                begin
                    sample_copy[frame_len] = int'($signed(s_tdata));
                    if (sample_copy[frame_len] > frame_max)
                    begin
                        frame_max = sample_copy[frame_len];
                        frame_top = frame_len;
                    end
                    frame_len++;
                end
                if (s_tlast)
                    close_frame(typed_peak);
            end

            if (m_tvalid && m_tready)
            begin
                if (pending_slots.size() == 0)
                    flag_mismatch("unexpected slot", m_tdata, '0);
                else
                begin
                    want = pending_slots.pop_front();
                    slots_checked++;
                    if (m_tdata !== 16'(want.index))
                        flag_mismatch("peak_index", m_tdata, 16'(want.index));
                    if (m_tuser !== want.filled)
                        flag_mismatch("slot_filled", 16'(m_tuser), 16'(want.filled));
                    if (m_tlast !== want.last)
                        flag_mismatch("last_slot", 16'(m_tlast), 16'(want.last));
                end
            end
        end

        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // One sample transaction: optional gap, then hold tvalid until accepted.
    // A gap lowers tvalid at the acceptance step; with no gap tvalid stays up.
    task automatic send_sample(input logic [15:0] value, input logic last,
                               input logic [10:0] peak, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= value;
        s_tlast    <= last;
        typed_peak <= peak;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
    endtask

    task automatic build_frame(input frame_shape_e shape, input int len);
        int pos;
        int level;
        frame_q.delete();
        level = $urandom_range(0, 65535);
        for (int k = 0; k < len; k++)
        begin
            case (shape)
                SHAPE_NOISE:    frame_q.push_back(16'($urandom));
                // low wiggle around zero, bumps added below
                SHAPE_BUMPS:    frame_q.push_back(16'(int'($urandom_range(0, 600)) - 300));
                SHAPE_NEGATIVE: frame_q.push_back(16'(int'($urandom_range(0, 32768)) - 32768));
                SHAPE_PLATEAU:  frame_q.push_back(16'(level));
                // every odd index a positive local maximum: fills 64 slots
                default:        frame_q.push_back(k % 2 ? 16'($urandom_range(1000, 32767))
                                                        : 16'(int'($urandom_range(0, 900)) - 900));
            endcase
        end
        if (shape == SHAPE_BUMPS || shape == SHAPE_PLATEAU)
        begin
            repeat ($urandom_range(1, 4))
            begin
                pos   = $urandom_range(0, len - 1);
                level = $urandom_range(1, 32767);
                frame_q[pos] = 16'(level);
                // twin bumps of equal height probe the first-largest rule
                if ($urandom_range(0, 2) == 0)
                    frame_q[$urandom_range(0, len - 1)] = 16'(level);
            end
        end
    endtask

    task automatic send_frame();
        bit burst;
        burst = ($urandom_range(0, 3) == 0);
        foreach (frame_q[k])
            send_sample(frame_q[k], k == frame_q.size() - 1, NO_PEAK, burst);
    endtask

    // Stop sending and wait until every expected slot has been seen. The
    // first negedge lets the monitor book the frame end that was just taken.
    task automatic await_idle();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_slots.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, with stretches of full-rate acceptance
    // ------------------------------------------------------------------
    initial
    begin : slot_sink
        int stall;
        int run_left;
        bit burst;
        m_tready = 1'b0;
        run_left = 0;
        burst    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (run_left == 0)
            begin
                burst    = ($urandom_range(0, 3) == 0);
                run_left = $urandom_range(8, 24);
            end
            run_left--;
            stall = burst ? 0 : $urandom_range(0, 10);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    // ends the run when nothing moves on either stream for too long
    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge clk);
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("threshold_peak_finder regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        vector_t      directed_rows[23];
        setting_t     settings[N_SETTINGS];
        setting_t     pick;
        frame_shape_e shape;
        int           phase;
        int           random_items;
        int           len;
        int           r;

        cfg_we     = 1'b0;
        cfg_addr   = CFG_THRESHOLD_FRACTION;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        typed_peak = NO_PEAK;

        // Directed frames under reset settings (fraction 1/2, distance 1,
        // 8 slots). Typed peaks are frames too short or flat to hold any
        // peak beyond the global one.
        directed_rows = '{
            '{16'h7FFF,    1'b1, 11'd0},      // lone full-scale sample
            '{16'h8000,    1'b1, 11'd0},      // nothing positive: peak falls back to 0
            '{-16'sd5,     1'b0, NO_PEAK},
            '{16'sd7,      1'b1, 11'd1},      // two samples, second is the max
            '{16'sd0,      1'b0, NO_PEAK},    // all zero: no positive, zero threshold
            '{16'sd0,      1'b0, NO_PEAK},
            '{16'sd0,      1'b1, 11'd0},
            '{16'sd10,     1'b0, NO_PEAK},    // local maxima around a global peak,
            '{16'sd100,    1'b0, NO_PEAK},    // some below the threshold
            '{16'sd20,     1'b0, NO_PEAK},
            '{16'sd300,    1'b0, NO_PEAK},
            '{16'sd40,     1'b0, NO_PEAK},
            '{16'sd200,    1'b0, NO_PEAK},
            '{16'sd5,      1'b1, NO_PEAK},
            '{16'sd5,      1'b0, NO_PEAK},    // tied maximum: first one wins, the
            '{16'sd50,     1'b0, NO_PEAK},    // twin is not strictly above it
            '{16'sd50,     1'b0, NO_PEAK},
            '{16'sd3,      1'b1, 11'd1},
            '{16'h8000,    1'b0, NO_PEAK},    // full-scale swings both ways
            '{16'h7FFF,    1'b0, NO_PEAK},
            '{16'h8000,    1'b0, NO_PEAK},
            '{16'h7FFF,    1'b0, NO_PEAK},
            '{16'h8000,    1'b1, NO_PEAK}
        };

        // register settings walked first; random ones follow
        settings = '{
            '{15'd0,     10'd1,    7'd64},    // zero threshold, all slots
            '{15'd32767, 10'd1,    7'd1},     // top fraction, single slot
            '{15'd16384, 10'd0,    7'd0},     // zero distance and zero slots fold to 1
            '{15'd8192,  10'd5,    7'd127},   // slots above 64 clamp to 64
            '{15'd24576, 10'd1023, 7'd16},    // widest distance
            '{15'd4096,  10'd2,    7'd64}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_sample(directed_rows[k].value, directed_rows[k].last,
                        directed_rows[k].peak, $urandom_range(0, 2) == 0);
        await_idle();

        // Random phases. Each one drains the block, programs all three
        // registers and streams a few frames; the drain doubles as the
        // sender holding off until every result is back.
        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS || phase < N_SETTINGS)
        begin
            if (phase < N_SETTINGS)
                pick = settings[phase];
            else
            begin
                pick.fraction = FRAC_W'($urandom_range(0, 32767));
                pick.spacing  = DIST_W'(($urandom_range(0, 7) == 0) ? $urandom_range(9, 1023)
                                                                    : $urandom_range(1, 8));
                pick.slots    = PEAKS_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                                     : $urandom_range(1, 64));
            end
            write_reg(CFG_THRESHOLD_FRACTION, pick.fraction);
            write_reg(CFG_MIN_DISTANCE, CFG_DATA_W'(pick.spacing));
            write_reg(CFG_MAX_PEAKS, CFG_DATA_W'(pick.slots));
            if (phase == 0)
                write_reg(CFG_SPARE, '1);

            repeat ($urandom_range(1, 3))
            begin
                r = $urandom_range(0, 19);
                if (r < 6)
                begin
                    shape = SHAPE_NOISE;
                    len   = $urandom_range(3, 12);
                end
                else if (r < 15)
                begin
                    shape = SHAPE_BUMPS;
                    len   = $urandom_range(8, 30);
                end
                else if (r < 17)
                begin
                    shape = SHAPE_NEGATIVE;
                    len   = $urandom_range(1, 10);
                end
                else
                begin
                    shape = SHAPE_PLATEAU;
                    len   = $urandom_range(2, 10);
                end
                build_frame(shape, len);
                send_frame();
                random_items += len;
            end

            // dense peaks to fill all 64 slots
            if (phase == 0)
            begin
                build_frame(SHAPE_ZIGZAG, 150);
                send_frame();
            end
            // overflow: the tail past the store depth is dropped, and its frame_end
            // closes the frame at full depth
            if (phase == 3)
            begin
                build_frame(SHAPE_NOISE, DEPTH + 6);
                send_frame();
            end

            await_idle();
            phase++;
        end

        $display("covered %0d samples in %0d frames over %0d register settings,",
                 samples_sent, frames_closed, phase + 1);
        $display("including an overflowing frame; %0d peak slots compared, %0d mismatches",
                 slots_checked, mismatches);
        if (mismatches == 0)
            $display("threshold_peak_finder regression: pass");
        else
            $display("threshold_peak_finder regression: fail");
        $finish;
    end

endmodule
